// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define DGSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, quiet during reset
`define DGSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/dgsp_pkg.sv =====
// Shared constants and types of the shortest-path unit.
package dgsp_pkg;

  localparam int MAX_NODES   = 32;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = NODE_BITS + 1;
  localparam int ADDR_BITS   = 2 * NODE_BITS;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 24;
  localparam int CFG_BITS    = 6;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_SAT = DIST_INF - DIST_BITS'(1);
  localparam logic [CNT_BITS-1:0]  NODE_COUNT_RESET = CNT_BITS'(32);

  typedef logic [DIST_BITS-1:0]   dist_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [NODE_BITS-1:0]   node_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NODE_COUNT  = 1'b0,
    CFG_SOURCE_NODE = 1'b1
  } cfg_index_t;

endpackage

// ===== rtl/dgsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/dgsp_alu.sv =====
// Shared saturating add and less-than compare for scan and relaxation.
module dgsp_alu (
  input  dgsp_pkg::dist_t   base,
  input  dgsp_pkg::weight_t addend,
  input  dgsp_pkg::dist_t   limit,
  output dgsp_pkg::dist_t   value,
  output logic              less
);
  import dgsp_pkg::*;

  logic [DIST_BITS:0] sum;

  always_comb begin
    sum = {1'b0, base} + (DIST_BITS+1)'(addend);
    if (addend != '0 && sum > {1'b0, DIST_SAT}) begin
      value = DIST_SAT;
    end else begin
      value = sum[DIST_BITS-1:0];
    end
    less = value < limit;
  end

endmodule

// ===== rtl/dense_graph_shortest_paths_unit.sv =====
// Dense-graph shortest-path unit: matrix load, Dijkstra sequencer and result stream.
// Each matrix word (start high while busy is low) is written and busy stays low, so
// words may arrive back to back. The word with load_done set starts a search from
// source_node over n = node_count nodes (clamped to 1..32); busy then stays high.
// Each round scans the n distances and, if a node is picked, reads its matrix row
// through the single weight RAM read port, all through one shared add/compare unit;
// each reached node costs one scan and one row read, then a last scan picks no node
// and the n results are sent. Results stream back to back with result_strobe high,
// node 0 first, final_result on the last; they cannot be held off. Configuration
// writes are registered; a search uses the values held when it starts.
module dense_graph_shortest_paths_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dgsp_pkg::NODE_BITS-1:0]    from_node,
  input  logic [dgsp_pkg::NODE_BITS-1:0]    to_node,
  input  logic [dgsp_pkg::WEIGHT_BITS-1:0]  edge_weight,
  input  logic                              load_done,
  input  logic                              cfg_write,
  input  logic [dgsp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [dgsp_pkg::CFG_BITS-1:0]     cfg_data,
  output logic                              result_strobe,
  output logic [dgsp_pkg::NODE_BITS-1:0]    vertex,
  output logic [dgsp_pkg::DIST_BITS-1:0]    distance,
  output logic                              reachable,
  output logic                              final_result
);
  import dgsp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RELAX, S_DRAIN, S_EMIT} state_t;

  state_t               state;
  logic [CNT_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]  n_reg;
  logic [CNT_BITS-1:0]  n_next;
  logic [CNT_BITS-1:0]  node_count;
  node_t                source_node;
  logic [MAX_NODES-1:0] settled;
  dist_t                best_dist [MAX_NODES];
  dist_t                least;
  dist_t                dist_pick;
  node_t                pick;
  logic                 found;
  logic                 pipe_valid;
  node_t                pipe_idx;

  node_t                scan_idx;
  logic                 scan_last;
  logic                 take;
  dist_t                least_now;
  node_t                pick_now;
  logic                 found_now;
  logic                 upd;
  logic                 accept;

  weight_t              rd_weight;
  dist_t                alu_base;
  weight_t              alu_addend;
  dist_t                alu_limit;
  dist_t                alu_value;
  logic                 alu_less;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign scan_idx = idx[NODE_BITS-1:0];
  assign scan_last = (idx == n_reg - CNT_BITS'(1));

  always_comb begin
    if (node_count == '0) begin
      n_next = CNT_BITS'(1);
    end else if (node_count > CNT_BITS'(MAX_NODES)) begin
      n_next = CNT_BITS'(MAX_NODES);
    end else begin
      n_next = node_count;
    end
  end

  dgsp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_NODES * MAX_NODES)
  ) u_weights (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr ({from_node, to_node}),
    .wr_data (edge_weight),
    .rd_addr ({pick, scan_idx}),
    .rd_data (rd_weight)
  );

  always_comb begin
    if (pipe_valid) begin
      alu_base   = dist_pick;
      alu_addend = rd_weight;
      alu_limit  = best_dist[pipe_idx];
    end else begin
      alu_base   = best_dist[scan_idx];
      alu_addend = '0;
      alu_limit  = least;
    end
  end

  dgsp_alu u_alu (
    .base   (alu_base),
    .addend (alu_addend),
    .limit  (alu_limit),
    .value  (alu_value),
    .less   (alu_less)
  );

  always_comb begin
    take      = !pipe_valid && !settled[scan_idx] && alu_less;
    least_now = take ? alu_value : least;
    pick_now  = take ? scan_idx : pick;
    found_now = found || take;
    upd       = pipe_valid && !settled[pipe_idx] && (rd_weight != '0) && alu_less;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      pipe_valid    <= 1'b0;
      node_count    <= NODE_COUNT_RESET;
      source_node   <= '0;
      settled       <= '0;
    end else begin
      result_strobe <= 1'b0;
      pipe_valid    <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == CFG_NODE_COUNT) begin
          node_count <= cfg_data[CNT_BITS-1:0];
        end else begin
          source_node <= cfg_data[NODE_BITS-1:0];
        end
      end
      if (upd) begin
        best_dist[pipe_idx] <= alu_value;
      end
      unique case (state)
        S_IDLE: begin
          if (start && load_done) begin
            for (int i = 0; i < MAX_NODES; i++) begin
              if (({1'b0, source_node} < n_next) && (node_t'(i) == source_node)) begin
                best_dist[i] <= '0;
              end else begin
                best_dist[i] <= DIST_INF;
              end
            end
            settled <= '0;
            idx     <= '0;
            least   <= DIST_INF;
            found   <= 1'b0;
            n_reg   <= n_next;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            idx <= '0;
            if (found_now) begin
              settled[pick_now] <= 1'b1;
              pick              <= pick_now;
              dist_pick         <= least_now;
              state             <= S_RELAX;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            idx   <= idx + CNT_BITS'(1);
            least <= least_now;
            pick  <= pick_now;
            found <= found_now;
          end
        end
        S_RELAX: begin
          pipe_valid <= 1'b1;
          pipe_idx   <= scan_idx;
          if (scan_last) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + CNT_BITS'(1);
          end
        end
        S_DRAIN: begin
          idx   <= '0;
          least <= DIST_INF;
          found <= 1'b0;
          state <= S_SCAN;
        end
        S_EMIT: begin
          result_strobe <= 1'b1;
          vertex        <= scan_idx;
          distance      <= best_dist[scan_idx];
          reachable     <= (best_dist[scan_idx] != DIST_INF);
          final_result  <= scan_last;
          if (scan_last) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + CNT_BITS'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/dgsp_checker.sv =====
// Port-level checker for the shortest-path unit, bound to the top level.
`include "assert_macros.svh"

module dgsp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           load_done,
  input logic                           result_strobe,
  input logic [dgsp_pkg::NODE_BITS-1:0] vertex,
  input logic                           final_result
);
  import dgsp_pkg::*;

  `DGSP_ASSERT_NOW(a_busy_mid_stream, result_strobe && !final_result, busy)
  `DGSP_ASSERT_NEXT(a_stream_gapless, result_strobe && !final_result, result_strobe)
  `DGSP_ASSERT_NEXT(a_stream_ends, result_strobe && final_result, !result_strobe)
  `DGSP_ASSERT_NEXT(a_vertex_step, result_strobe && !final_result, vertex == NODE_BITS'($past(vertex) + 1'b1))
  `DGSP_ASSERT_NEXT(a_load_one_cycle, start && !busy && !load_done, !busy)

endmodule

bind dense_graph_shortest_paths_unit dgsp_checker u_dgsp_checker (.*);
